FILE: rtl/tcm_pkg.sv
// ----------------------------------------------------------------------------
// tcm_pkg
// Shared types and constants of the touch coordinate mapper: register
// indexes, default scale values and the status of the scaling unit.
// ----------------------------------------------------------------------------
package tcm_pkg;

   // register index port width and register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_SWAP_AXES     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_X      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_Y      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RAW_MAX_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RAW_MAX_Y     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd6;

   // display size registers and defaults
   localparam int SIZE_W = 10;
   localparam logic [SIZE_W-1:0] DEF_SCREEN = 10'd240;

   // default raw maximum, also the divisor used when raw maximum is zero
   localparam int DEF_RAW_MAX = 4095;
   localparam int DEF_RAW_W   = 12;

   // mapped position width
   localparam int POS_W = 16;

   // status of the scaling unit
   typedef struct packed {
      logic busy;
      logic done;
   } scale_stat_type;

endpackage

FILE: rtl/tcm_if.sv
// ----------------------------------------------------------------------------
// tcm_req_if / tcm_rsp_if
// Valid/ready channels of the touch coordinate mapper: touch samples in,
// press and release events out.
// ----------------------------------------------------------------------------
interface tcm_req_if #(
   parameter int RAW_BITS = 12
);
   logic                valid;
   logic                ready;
   logic                touching;
   logic [RAW_BITS-1:0] raw_x;
   logic [RAW_BITS-1:0] raw_y;

   modport source (output valid, output touching, output raw_x, output raw_y,
                   input ready);
   modport sink   (input valid, input touching, input raw_x, input raw_y,
                   output ready);
endinterface

interface tcm_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [tcm_pkg::POS_W-1:0]        pos_x;
   logic signed [tcm_pkg::POS_W-1:0]        pos_y;
   logic                                    is_press;

   modport source (output valid, output pos_x, output pos_y, output is_press,
                   input ready);
   modport sink   (input valid, input pos_x, input pos_y, input is_press,
                   output ready);
endinterface

FILE: rtl/tcm_scale.sv
// ----------------------------------------------------------------------------
// tcm_scale
// Scales one signed axis value: one multiply by the display size, then a
// restoring divide by the raw maximum, one quotient bit per cycle. The
// quotient truncates toward zero and wraps to the position width.
// ----------------------------------------------------------------------------
module tcm_scale #(
   parameter int VAL_W = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [VAL_W-1:0]           value,
   input  logic [tcm_pkg::SIZE_W-1:0]        size,
   input  logic [VAL_W-2:0]                  divisor,
   output tcm_pkg::scale_stat_type           stat,
   output logic [tcm_pkg::POS_W-1:0]         result
);

   localparam int DIV_W  = VAL_W - 1;
   localparam int PROD_W = DIV_W + tcm_pkg::SIZE_W;
   localparam int CNT_W  = $clog2(PROD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

   logic [PROD_W-1:0]          quo_ff, quo_in;
   logic [DIV_W-1:0]           rem_ff, rem_in;
   logic [DIV_W-1:0]           div_ff;
   logic                       neg_ff;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [tcm_pkg::POS_W-1:0]  res_ff, res_in;

   logic [VAL_W-1:0]           neg_val;
   logic [DIV_W-1:0]           mag;
   logic [PROD_W-1:0]          prod;
   logic [DIV_W:0]             rem_sh;
   logic                       ge;
   logic [DIV_W:0]             rem_sub;
   logic [PROD_W-1:0]          quo_step;
   logic [tcm_pkg::POS_W-1:0]  quo_low;

   // magnitude and product, taken at start
   assign neg_val = -value;
   assign mag     = value[VAL_W-1] ? neg_val[DIV_W-1:0] : value[DIV_W-1:0];
   assign prod    = PROD_W'(mag) * PROD_W'(size);

   // one restoring divide step
   assign rem_sh   = {rem_ff, quo_ff[PROD_W-1]};
   assign ge       = rem_sh >= {1'b0, div_ff};
   assign rem_sub  = rem_sh - {1'b0, div_ff};
   assign quo_step = {quo_ff[PROD_W-2:0], ge};
   assign quo_low  = quo_step[tcm_pkg::POS_W-1:0];

   // sequencing of the divide
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (start) begin
         quo_in  = prod;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -quo_low : quo_low;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operand and datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      if (start) begin
         div_ff <= divisor;
         neg_ff <= value[VAL_W-1];
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

   // checks
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("scale unit not busy after start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("scale unit done while still busy");
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && cnt_ff == CNT_LAST |=> done_ff)
      else $error("scale unit missed done after last step");

endmodule

FILE: rtl/touch_coordinate_mapper.sv
// ----------------------------------------------------------------------------
// touch_coordinate_mapper
// Maps polled touch samples to screen coordinates and emits press and
// release events.
//
//   port      dir   protocol     contents
//   req_chan  in    valid/ready  touching, raw_x, raw_y
//   rsp_chan  out   valid/ready  pos_x, pos_y, is_press
//   csr_*     in    write only   csr_we, csr_index, csr_wdata
//
// A pressed sample is scaled axis by axis in one shared scaling unit: each
// axis passes a start state, MAX_W+10 divide steps and a done strobe (MAX_W is
// RAW_BITS, at least 12). An unpressed sample goes from intake straight to the
// finish state. req_chan is ready only between samples. The result sits in an
// output register, so one more sample is taken in while rsp_chan stalls; the
// result after that waits in the sequencer and holds off req_chan. Synchronous
// active-high reset; no clearing pass.
// ----------------------------------------------------------------------------
module touch_coordinate_mapper #(
   parameter int RAW_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tcm_req_if.sink                              req_chan,
   tcm_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [tcm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [((RAW_BITS > tcm_pkg::SIZE_W) ? RAW_BITS : tcm_pkg::SIZE_W)-1:0]
                                                csr_wdata
);

   localparam int MAX_W = (RAW_BITS > tcm_pkg::DEF_RAW_W) ? RAW_BITS : tcm_pkg::DEF_RAW_W;
   localparam int VAL_W = MAX_W + 1;
   localparam int SW    = tcm_pkg::SIZE_W;
   localparam int PW    = tcm_pkg::POS_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   localparam logic [MAX_W-1:0] RAW_MAX_DEF = MAX_W'(tcm_pkg::DEF_RAW_MAX);

   // configuration registers
   logic              swap_ff, inv_x_ff, inv_y_ff;
   logic [MAX_W-1:0]  rmax_x_ff, rmax_y_ff;
   logic [SW-1:0]     width_ff, height_ff;

   // sequencer and sample state
   logic [1:0]               state_ff, state_in;
   logic                     axis_ff, axis_in;
   logic                     touch_ff;
   logic signed [VAL_W-1:0]  vx_ff, vy_ff;
   logic                     held_ff, held_in;
   logic [PW-1:0]            last_x_ff, last_x_in, last_y_ff, last_y_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]            rsp_x_ff, rsp_y_ff;
   logic                     rsp_press_ff;

   logic                     req_fire, rsp_fire, out_free, emit, load_out;
   logic [RAW_BITS-1:0]      sx, sy;
   logic signed [VAL_W-1:0]  vx, vy;
   logic                     start;
   logic signed [VAL_W-1:0]  sc_value;
   logic [SW-1:0]            sc_size;
   logic [MAX_W-1:0]         sc_div;
   tcm_pkg::scale_stat_type  sc_stat;
   logic [PW-1:0]            sc_result;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = touch_ff || held_ff;
   assign load_out = (state_ff == ST_FIN) && emit && out_free;
   assign start    = (state_ff == ST_START);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff   <= 1'b0;
         inv_x_ff  <= 1'b0;
         inv_y_ff  <= 1'b0;
         rmax_x_ff <= RAW_MAX_DEF;
         rmax_y_ff <= RAW_MAX_DEF;
         width_ff  <= tcm_pkg::DEF_SCREEN;
         height_ff <= tcm_pkg::DEF_SCREEN;
      end else if (csr_we) begin
         unique case (csr_index)
            tcm_pkg::REG_SWAP_AXES:     swap_ff   <= csr_wdata[0];
            tcm_pkg::REG_INVERT_X:      inv_x_ff  <= csr_wdata[0];
            tcm_pkg::REG_INVERT_Y:      inv_y_ff  <= csr_wdata[0];
            tcm_pkg::REG_RAW_MAX_X:     rmax_x_ff <= MAX_W'(csr_wdata[RAW_BITS-1:0]);
            tcm_pkg::REG_RAW_MAX_Y:     rmax_y_ff <= MAX_W'(csr_wdata[RAW_BITS-1:0]);
            tcm_pkg::REG_SCREEN_WIDTH:  width_ff  <= csr_wdata[SW-1:0];
            tcm_pkg::REG_SCREEN_HEIGHT: height_ff <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // swap and invert of the incoming sample
   assign sx = swap_ff ? req_chan.raw_y : req_chan.raw_x;
   assign sy = swap_ff ? req_chan.raw_x : req_chan.raw_y;
   assign vx = inv_x_ff ? $signed(VAL_W'(rmax_x_ff)) - $signed(VAL_W'(sx))
                        : $signed(VAL_W'(sx));
   assign vy = inv_y_ff ? $signed(VAL_W'(rmax_y_ff)) - $signed(VAL_W'(sy))
                        : $signed(VAL_W'(sy));

   // operands of the current axis, with zero defaults
   always_comb begin
      if (axis_ff) begin
         sc_value = vy_ff;
         sc_size  = (height_ff == '0) ? tcm_pkg::DEF_SCREEN : height_ff;
         sc_div   = (rmax_y_ff == '0) ? RAW_MAX_DEF : rmax_y_ff;
      end else begin
         sc_value = vx_ff;
         sc_size  = (width_ff == '0) ? tcm_pkg::DEF_SCREEN : width_ff;
         sc_div   = (rmax_x_ff == '0) ? RAW_MAX_DEF : rmax_x_ff;
      end
   end

   tcm_scale #(
      .VAL_W (VAL_W)
   ) u_scale (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .value   (sc_value),
      .size    (sc_size),
      .divisor (sc_div),
      .stat    (sc_stat),
      .result  (sc_result)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      held_in      = held_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               axis_in  = 1'b0;
               state_in = req_chan.touching ? ST_START : ST_FIN;
            end
         end
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (sc_stat.done) begin
               if (axis_ff) begin
                  last_y_in = sc_result;
                  state_in  = ST_FIN;
               end else begin
                  last_x_in = sc_result;
                  axis_in   = 1'b1;
                  state_in  = ST_START;
               end
            end
         end
         ST_FIN: begin
            if (!emit) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               held_in      = touch_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         held_ff      <= 1'b0;
         last_x_ff    <= '1;
         last_y_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         held_ff      <= held_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sample and result word registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         touch_ff <= req_chan.touching;
         vx_ff    <= vx;
         vy_ff    <= vy;
      end
      if (load_out) begin
         rsp_x_ff     <= last_x_ff;
         rsp_y_ff     <= last_y_ff;
         rsp_press_ff <= touch_ff;
      end
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.pos_x    = $signed(rsp_x_ff);
   assign rsp_chan.pos_y    = $signed(rsp_y_ff);
   assign rsp_chan.is_press = rsp_press_ff;

   // checks
   a_press_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.touching |=> state_ff == ST_START && !axis_ff)
      else $error("pressed sample did not start scaling");
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      load_out && !touch_ff |=> !held_ff && rsp_valid_ff && !rsp_press_ff)
      else $error("release word not issued or held flag kept");
   a_silent_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && !touch_ff && !held_ff |=> state_ff == ST_IDLE
         && $stable(rsp_valid_ff) || state_ff == ST_IDLE && !rsp_valid_ff)
      else $error("idle release produced a word");
   a_scale_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !sc_stat.busy)
      else $error("scale unit started while busy");

endmodule
